>>> src/dfs_pkg.sv
`default_nettype none

package dfs_pkg;

   // Build-time defaults for the top-level parameters
   localparam int DELIM_MAX_DEFAULT        = 4;
   localparam int FIELD_COUNT_BITS_DEFAULT = 16;

   // Fixed port widths
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int LEN_W      = 3;
   localparam int MAXF_W     = 16;
   localparam int INDEX_W    = 16;

   // Register map
   localparam logic [CSR_IDX_W-1:0] REG_DELIM_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELIM_LEN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_FIELDS  = 2'd2;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] DELIM_BYTES_RESET = 32'd44;
   localparam logic [LEN_W-1:0]      DELIM_LEN_RESET   = 3'd1;
   localparam logic [MAXF_W-1:0]     MAX_FIELDS_RESET  = 16'd0;

   typedef enum logic [1:0] {
      CMD_DATA     = 2'd0,
      CMD_DATA_END = 2'd1,
      CMD_END      = 2'd2,
      CMD_NOP      = 2'd3
   } cmd_type;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Window cell move for one cycle
   typedef enum logic [1:0] {
      SH_HOLD = 2'd0,
      SH_ONE  = 2'd1,
      SH_LEN  = 2'd2
   } shift_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         out_byte;
      logic [INDEX_W-1:0] field_index;
      logic               field_empty;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/dfs_window_cell.sv
`default_nettype none

module dfs_window_cell (
   input  wire logic               clock,
   input  wire dfs_pkg::shift_type shift,
   input  wire logic               load,
   input  wire logic [7:0]         new_byte,
   input  wire logic [7:0]         nbr_byte,
   input  wire logic [7:0]         far_byte,
   input  wire logic [7:0]         delim_byte,
   output logic      [7:0]         cell_byte,
   output logic                    match
);
   import dfs_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      unique case (shift)
         SH_ONE:  byte_in = nbr_byte;
         SH_LEN:  byte_in = far_byte;
         default: byte_in = byte_ff;
      endcase
      // new byte lands in the first free slot after the shift
      if (load) begin
         byte_in = new_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;
   assign match     = (byte_ff == delim_byte);

endmodule

`default_nettype wire

>>> src/dfs_rsp_fifo.sv
`default_nettype none

module dfs_rsp_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dfs_pkg::rsp_type push_data,
   output logic                  space,
   input  wire logic             pop_ready,
   output logic                  head_valid,
   output dfs_pkg::rsp_type      head
);
   import dfs_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign space      = (count_ff < 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];
   assign pop        = head_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> src/delimiter_field_splitter.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------------
// req      | in        | req_valid/req_ready  | req_cmd[1:0], req_data_byte[7:0]
// rsp      | out       | rsp_valid/rsp_ready  | rsp_result_kind, rsp_out_byte[7:0],
//          |           |                      | rsp_field_index[15:0], rsp_field_empty, rsp_last
// csr      | in        | csr_we (no wait)     | csr_index[1:0], csr_wdata[31:0]
//
// One req transaction per cycle in steady state. Each cycle the window chain does one
// step (emit front byte, close a field, or flush), so the rsp side moves at most one
// transaction per cycle; an item causing k results keeps req_ready low while the chain
// steps through them, and longer while a stalled rsp side keeps the rsp queue full.
// Synchronous active-high reset clears the window count, field counter and flags, and
// loads the delimiter ',' length 1, no field limit. A 2-entry rsp queue decouples the
// sides: req_ready depends only on registered state, never on rsp_ready.
`default_nettype none

module delimiter_field_splitter #(
   parameter int DELIM_MAX        = dfs_pkg::DELIM_MAX_DEFAULT,
   parameter int FIELD_COUNT_BITS = dfs_pkg::FIELD_COUNT_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [7:0]                    req_data_byte,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_result_kind,
   output logic [7:0]                         rsp_out_byte,
   output logic [dfs_pkg::INDEX_W-1:0]        rsp_field_index,
   output logic                               rsp_field_empty,
   output logic                               rsp_last,
   // configuration writes
   input  wire logic                          csr_we,
   input  wire logic [dfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dfs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dfs_pkg::*;

   localparam int CNT_W = $clog2(DELIM_MAX + 1);
   // wide enough for both the field counter plus one and the 16-bit limit
   localparam int SUM_W = ((FIELD_COUNT_BITS > MAXF_W) ? FIELD_COUNT_BITS : MAXF_W) + 1;

   // ---------------- configuration registers ----------------
   logic [CSR_DATA_W-1:0] delim_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [MAXF_W-1:0]     maxf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_BYTES_RESET;
         len_ff   <= DELIM_LEN_RESET;
         maxf_ff  <= MAX_FIELDS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DELIM_BYTES: delim_ff <= csr_wdata;
            REG_DELIM_LEN:   len_ff   <= csr_wdata[LEN_W-1:0];
            REG_MAX_FIELDS:  maxf_ff  <= csr_wdata[MAXF_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // Effective delimiter length: 0 acts as 1, clipped to the window size
   logic [3:0]       len_wide;
   logic [CNT_W-1:0] act_len;

   always_comb begin
      len_wide = {1'b0, len_ff};
      if (len_wide == 4'd0) begin
         act_len = CNT_W'(1);
      end else if (len_wide > 4'(DELIM_MAX)) begin
         act_len = CNT_W'(DELIM_MAX);
      end else begin
         act_len = CNT_W'(len_wide);
      end
   end

   // ---------------- stream state ----------------
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [FIELD_COUNT_BITS-1:0] fields_ff, fields_in;
   logic                        has_ff, has_in;     // current field has seen a byte
   logic                        armed_ff, armed_in; // a data byte arrived, drain matches
   logic                        flush_ff, flush_in; // end of string pending

   // ---------------- window chain ----------------
   shift_type  shift;
   logic       load;
   logic [7:0] cell_byte  [DELIM_MAX];
   logic [7:0] ext_byte   [2*DELIM_MAX];
   logic [7:0] far_byte   [DELIM_MAX];
   logic       cell_match [DELIM_MAX];
   logic [CNT_W-1:0] count_a;

   // zero padding past the end of the chain keeps shift sources in range
   always_comb begin
      for (int i = 0; i < 2*DELIM_MAX; i++) begin
         ext_byte[i] = (i < DELIM_MAX) ? cell_byte[i % DELIM_MAX] : 8'd0;
      end
      for (int i = 0; i < DELIM_MAX; i++) begin
         far_byte[i] = 8'd0;
         for (int k = 1; k <= DELIM_MAX; k++) begin
            if (act_len == CNT_W'(k)) begin
               far_byte[i] = ext_byte[i + k];
            end
         end
      end
   end

   for (genvar g = 0; g < DELIM_MAX; g++) begin : g_cell
      logic [7:0] dbyte;
      if (g < 4) begin : g_cfg
         assign dbyte = delim_ff[8*g +: 8];
      end else begin : g_zero
         assign dbyte = 8'd0;  // no register bits beyond the fourth byte
      end

      dfs_window_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .load       (load && (count_a == CNT_W'(g))),
         .new_byte   (req_data_byte),
         .nbr_byte   (ext_byte[g + 1]),
         .far_byte   (far_byte[g]),
         .delim_byte (dbyte),
         .cell_byte  (cell_byte[g]),
         .match      (cell_match[g])
      );
   end

   // ---------------- step control ----------------
   logic             hit_all;
   logic             matching_on;
   logic             hit;
   logic             do_match;
   logic             do_flush;
   logic             act;
   logic             fifo_space;
   logic             push;
   rsp_type          push_data;
   logic             armed_a;
   logic             flush_a;
   logic             req_fire;
   cmd_type          cmd;
   logic [SUM_W-1:0] fields_wide;

   assign fields_wide = SUM_W'(fields_ff);
   assign cmd         = cmd_type'(req_cmd);

   always_comb begin
      // delimiter compare over the first act_len cells
      hit_all = 1'b1;
      for (int i = 0; i < DELIM_MAX; i++) begin
         if ((CNT_W'(i) < act_len) && !cell_match[i]) begin
            hit_all = 1'b0;
         end
      end
      // matching stops once the current field is the last allowed one
      matching_on = (maxf_ff == '0) ||
                    ((fields_wide + SUM_W'(1)) < SUM_W'(maxf_ff));
      hit = matching_on && hit_all;
   end

   always_comb begin
      do_match = armed_ff && (count_ff >= act_len);
      do_flush = !do_match && flush_ff;
      act      = (do_match || do_flush) && fifo_space;

      shift     = SH_HOLD;
      count_a   = count_ff;
      fields_in = fields_ff;
      has_in    = has_ff;
      flush_a   = flush_ff;
      push      = 1'b0;
      push_data.kind        = KIND_BYTE;
      push_data.out_byte    = cell_byte[0];
      push_data.field_index = fields_wide[INDEX_W-1:0];
      push_data.field_empty = 1'b0;
      push_data.last        = 1'b0;

      if (act) begin
         push = 1'b1;
         if (do_match && hit) begin
            // delimiter found: close field, drop the delimiter bytes
            push_data.kind        = KIND_END;
            push_data.out_byte    = 8'd0;
            push_data.field_empty = !has_ff;
            if (fields_ff != '1) begin
               fields_in = fields_ff + FIELD_COUNT_BITS'(1);
            end
            has_in  = 1'b0;
            shift   = SH_LEN;
            count_a = count_ff - act_len;
         end else if (do_match || (count_ff != '0)) begin
            // front byte belongs to the current field
            has_in  = 1'b1;
            shift   = SH_ONE;
            count_a = count_ff - CNT_W'(1);
         end else begin
            // window empty at end of string: final close, back to start
            push_data.kind        = KIND_END;
            push_data.out_byte    = 8'd0;
            push_data.field_empty = !has_ff;
            push_data.last        = 1'b1;
            fields_in = '0;
            has_in    = 1'b0;
            flush_a   = 1'b0;
         end
      end

      armed_a   = armed_ff && (count_a >= act_len);
      req_ready = !armed_a && !flush_a;
      req_fire  = req_valid && req_ready;

      count_in = count_a;
      armed_in = armed_a;
      flush_in = flush_a;
      load     = 1'b0;

      if (req_fire) begin
         unique case (cmd)
            CMD_DATA: begin
               load     = (count_a < CNT_W'(DELIM_MAX));
               count_in = load ? count_a + CNT_W'(1) : count_a;
               armed_in = 1'b1;
            end
            CMD_DATA_END: begin
               load     = (count_a < CNT_W'(DELIM_MAX));
               count_in = load ? count_a + CNT_W'(1) : count_a;
               armed_in = 1'b1;
               flush_in = 1'b1;
            end
            CMD_END: begin
               flush_in = 1'b1;
            end
            CMD_NOP: ;  // ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         fields_ff <= '0;
         has_ff    <= 1'b0;
         armed_ff  <= 1'b0;
         flush_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         fields_ff <= fields_in;
         has_ff    <= has_in;
         armed_ff  <= armed_in;
         flush_ff  <= flush_in;
      end
   end

   // ---------------- response queue ----------------
   rsp_type head;

   dfs_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .space      (fifo_space),
      .pop_ready  (rsp_ready),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_result_kind = head.kind;
   assign rsp_out_byte    = head.out_byte;
   assign rsp_field_index = head.field_index;
   assign rsp_field_empty = head.field_empty;
   assign rsp_last        = head.last;

endmodule

`default_nettype wire

>>> src/dfs_checker.sv
`default_nettype none

module dfs_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic                   rsp_result_kind,
   input wire logic [7:0]             rsp_out_byte,
   input wire logic [dfs_pkg::INDEX_W-1:0] rsp_field_index,
   input wire logic                   rsp_field_empty,
   input wire logic                   rsp_last
);
   import dfs_pkg::*;

   logic               rsp_fire;
   logic               after_last_ff, after_last_in;
   logic               prev_byte_ff, prev_byte_in;
   logic [INDEX_W-1:0] prev_index_ff, prev_index_in;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      after_last_in = after_last_ff;
      prev_byte_in  = prev_byte_ff;
      prev_index_in = prev_index_ff;
      if (rsp_fire) begin
         after_last_in = (rsp_result_kind == KIND_END) && rsp_last;
         prev_byte_in  = (rsp_result_kind == KIND_BYTE);
         prev_index_in = rsp_field_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_last_ff <= 1'b1;
         prev_byte_ff  <= 1'b0;
         prev_index_ff <= '0;
      end else begin
         after_last_ff <= after_last_in;
         prev_byte_ff  <= prev_byte_in;
         prev_index_ff <= prev_index_in;
      end
   end

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_field_index) &&
      $stable(rsp_field_empty) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // out of reset: nothing queued, ready for a request
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

   // a new string starts at field zero
   a_new_string: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && after_last_ff |-> rsp_field_index == '0)
      else $error("string did not restart at field zero");

   // after a field byte, the next transaction stays in the same field
   a_same_field: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !after_last_ff && prev_byte_ff |-> rsp_field_index == prev_index_ff)
      else $error("field index moved without a field end");

endmodule

bind delimiter_field_splitter dfs_checker u_dfs_checker (.*);

`default_nettype wire
